// ===== rtl/core/sitda_pkg.sv =====
// Shared constants and types for the signed integer to decimal text converter.
// No dependencies; imported by the channel interfaces and the top level.
package sitda_pkg;

	localparam int VALUE_W = 32;
	localparam int DIGITS  = 10;
	localparam int DIGIT_W = 4;
	localparam int BCD_W   = DIGITS * DIGIT_W;
	localparam int POS_W   = 4;
	localparam int CHAR_W  = 8;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

	typedef logic [BCD_W-1:0]   bcd_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [CHAR_W-1:0]  char_t;

endpackage

// ===== rtl/core/sitda_in_if.sv =====
// Request channel carrying one signed integer per request.
// Depends on sitda_pkg for the field width.
interface sitda_in_if
	import sitda_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/sitda_out_if.sv =====
// Result channel carrying one ASCII character and its end-of-text flag.
// Depends on sitda_pkg for the character type.
interface sitda_out_if
	import sitda_pkg::*;
();
	logic  valid;
	logic  ready;
	char_t ascii_char;
	logic  is_last;

	modport source (output valid, output ascii_char, output is_last, input ready);
	modport sink   (input valid, input ascii_char, input is_last, output ready);
endinterface

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text. Each request on num carries one
// two's complement value; text returns its characters most significant first,
// a '-' ahead of negative values, no leading zeros, a single '0' for zero, and
// is_last high on the final character, so one value yields 1 to 11 results.
// The most negative value comes out exactly as -2147483648. A value passes
// through the sign and magnitude stage, the byte conversion stages, the
// leading-digit stage and the serializer register before its first character
// is offered. The serializer sends one character per cycle while text.ready is
// high, and it takes the next waiting value while the last character of a run
// leaves; the one-character result channel limits the rate. Depends on
// sitda_pkg and the two channel interfaces.
module signed_int_to_decimal_ascii
	import sitda_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	sitda_in_if.sink     num,
	sitda_out_if.source  text
);

	// Eight double-dabble steps: add 3 to each digit of five or more, then
	// shift in the next binary bit, most significant bit first.
	function automatic bcd_t dabble8(input bcd_t b, input logic [7:0] bits);
		bcd_t t;
		t = b;
		for (int i = 7; i >= 0; i--) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (t[d*DIGIT_W +: DIGIT_W] >= 4'd5)
					t[d*DIGIT_W +: DIGIT_W] = t[d*DIGIT_W +: DIGIT_W] + 4'd3;
			end
			t = {t[BCD_W-2:0], bits[i]};
		end
		return t;
	endfunction

	// Stage 1: sign and magnitude.
	logic               vld_s1, neg_s1;
	logic [VALUE_W-1:0] mag_s1;
	// Stages 2 to 5: one byte of the magnitude converted per stage.
	logic               vld_s2, neg_s2, vld_s3, neg_s3, vld_s4, neg_s4, vld_s5, neg_s5;
	logic [23:0]        bin_s2;
	logic [15:0]        bin_s3;
	logic [7:0]         bin_s4;
	bcd_t               bcd_s2, bcd_s3, bcd_s4, bcd_s5;
	// Stage 6: position of the leading nonzero digit.
	logic               vld_s6, neg_s6;
	bcd_t               bcd_s6;
	pos_t               top_s6;

	// Output serializer.
	logic  busy_q, sign_q;
	bcd_t  bcd_q;
	pos_t  pos_q;

	logic  rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic  out_fire, out_last, load;
	pos_t  top_c;
	logic  digits_ok;

	assign out_last = !sign_q && (pos_q == '0);
	assign out_fire = text.valid && text.ready;
	// Take the next value when idle or while the final character leaves.
	assign load     = !busy_q || (out_fire && out_last);

	// Backpressure: a stage takes new data when empty or when it drains.
	assign rdy_s6 = !vld_s6 || load;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign num.ready = rdy_s1;

	always_comb begin
		top_c = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_s5[d*DIGIT_W +: DIGIT_W] != '0)
				top_c = POS_W'(d);
		end
	end

	always_comb begin
		digits_ok = 1'b1;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_s6[d*DIGIT_W +: DIGIT_W] > 4'd9)
				digits_ok = 1'b0;
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= num.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// Payload of the pipeline: advance only where a stage takes new data.
	always_ff @(posedge clk) begin
		if (rdy_s1 && num.valid) begin
			neg_s1 <= num.value[VALUE_W-1];
			mag_s1 <= num.value[VALUE_W-1] ? (~num.value + 1'b1) : num.value;
		end
		if (rdy_s2 && vld_s1) begin
			neg_s2 <= neg_s1;
			bcd_s2 <= dabble8('0, mag_s1[31:24]);
			bin_s2 <= mag_s1[23:0];
		end
		if (rdy_s3 && vld_s2) begin
			neg_s3 <= neg_s2;
			bcd_s3 <= dabble8(bcd_s2, bin_s2[23:16]);
			bin_s3 <= bin_s2[15:0];
		end
		if (rdy_s4 && vld_s3) begin
			neg_s4 <= neg_s3;
			bcd_s4 <= dabble8(bcd_s3, bin_s3[15:8]);
			bin_s4 <= bin_s3[7:0];
		end
		if (rdy_s5 && vld_s4) begin
			neg_s5 <= neg_s4;
			bcd_s5 <= dabble8(bcd_s4, bin_s4);
		end
		if (rdy_s6 && vld_s5) begin
			neg_s6 <= neg_s5;
			bcd_s6 <= bcd_s5;
			top_s6 <= top_c;
		end
	end

	// Serializer control: the sign goes first, then digits from the leading one down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= vld_s6;
			sign_q <= neg_s6 && vld_s6;
			pos_q  <= top_s6;
		end else if (out_fire) begin
			if (sign_q)
				sign_q <= 1'b0;
			else
				pos_q <= pos_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && vld_s6)
			bcd_q <= bcd_s6;
	end

	assign text.valid      = busy_q;
	assign text.is_last    = out_last;
	assign text.ascii_char = sign_q ? CHAR_MINUS
		: CHAR_ZERO + {4'b0000, bcd_q[{pos_q, 2'b00} +: DIGIT_W]};

	// The sign character never closes a run.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && sign_q |-> !text.is_last)
		else $error("sign character flagged as last");

	// After a character that is not the last, the run continues.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !out_last |=> text.valid)
		else $error("run ended before its last character");

	// A stalled value at the serializer input holds.
	a_s6_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && !load |=> vld_s6 && $stable(bcd_s6) && $stable(top_s6))
		else $error("stage 6 changed while stalled");

	// Conversion leaves only decimal digits.
	a_digits_ok: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> digits_ok)
		else $error("non-decimal digit after conversion");

endmodule
